/* design/lr4x_pkg.sv */
// Shared types and constants for the multi-voice crossover split.
`timescale 1ns / 1ps

package lr4x_pkg;

    // Coefficient register file
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_LOW_FF0  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOW_FF1  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOW_FF2  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_FF0 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_FF1 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_FF2 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FB1      = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_FB2      = 3'd7;

    // Product taps of one biquad, then a drain tap for the last product
    localparam int TAP_W = 3;
    localparam logic [TAP_W-1:0] TAP_X0    = 3'd0;
    localparam logic [TAP_W-1:0] TAP_X1    = 3'd1;
    localparam logic [TAP_W-1:0] TAP_X2    = 3'd2;
    localparam logic [TAP_W-1:0] TAP_Y1    = 3'd3;
    localparam logic [TAP_W-1:0] TAP_Y2    = 3'd4;
    localparam logic [TAP_W-1:0] TAP_DRAIN = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_ROUND,
        ST_FINISH
    } seq_state_t;

    // Multiply-accumulate control
    typedef struct packed {
        logic init;     // load accumulator with the rounding offset
        logic mul_en;   // register a new product
        logic acc_en;   // add the held product
    } mac_ctrl_t;

    // History memory control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;   // drop history of the voices in the clear mask
    } hist_ctrl_t;

endpackage

/* design/lr4x_coef_regs.sv */
// Coefficient register file with a plain write port and one selected read.
`timescale 1ns / 1ps

module lr4x_coef_regs #(
    parameter int COEF_BITS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [lr4x_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [COEF_BITS-1:0]                  cfg_wdata,
    input  logic [lr4x_pkg::REG_IDX_W-1:0]        rd_index,
    output logic signed [COEF_BITS-1:0]           rd_coef
);

    logic [COEF_BITS-1:0] coef_reg [lr4x_pkg::NUM_REGS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lr4x_pkg::NUM_REGS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            coef_reg[cfg_index] <= cfg_wdata;
        end
    end

    assign rd_coef = $signed(coef_reg[rd_index]);

endmodule

/* design/lr4x_hist_mem.sv */
// Biquad history memory: one word of x1, x2, y1, y2 per voice, band and stage.
`timescale 1ns / 1ps

module lr4x_hist_mem #(
    parameter int VOICES      = 4,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  lr4x_pkg::hist_ctrl_t                   ctrl,
    input  logic [$clog2(VOICES*4)-1:0]            addr,
    input  logic [VOICES-1:0]                      clr_mask,
    input  logic [4*SAMPLE_BITS-1:0]               wr_word,
    output logic [4*SAMPLE_BITS-1:0]               rd_word
);

    localparam int DEPTH  = VOICES * 4;
    localparam int WORD_W = 4 * SAMPLE_BITS;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;

    // Entry i belongs to voice i/4; an entry never written reads as zero
    always_comb begin
        valid_next = valid_reg;
        if (ctrl.clr_en) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (clr_mask[i / 4]) begin
                    valid_next[i] = 1'b0;
                end
            end
        end
        if (ctrl.wr_en) begin
            valid_next[addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (ctrl.rd_en) begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[addr] <= wr_word;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_word = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* design/lr4x_mac.sv */
// Shared multiplier, accumulator and round-half-up saturation to the sample grid.
`timescale 1ns / 1ps

module lr4x_mac #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_BITS      = 32,
    parameter int COEF_FRAC_BITS = 29
) (
    input  logic                           aclk,
    input  lr4x_pkg::mac_ctrl_t            ctrl,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    input  logic signed [COEF_BITS-1:0]    coef,
    output logic signed [SAMPLE_BITS-1:0]  result
);

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SMAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMIN = -(ACC_W'(1) << (SAMPLE_BITS - 1));

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  shifted;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= sample * coef;
        end
        if (ctrl.init) begin
            acc_reg <= HALF;
        end else if (ctrl.acc_en) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Floor after the half-LSB offset, then clamp
    always_comb begin
        shifted = acc_reg >>> COEF_FRAC_BITS;
        if (shifted > SMAX) begin
            result = SMAX[SAMPLE_BITS-1:0];
        end else if (shifted < SMIN) begin
            result = SMIN[SAMPLE_BITS-1:0];
        end else begin
            result = shifted[SAMPLE_BITS-1:0];
        end
    end

endmodule

/* design/lr4_crossover_split.sv */
// Top level of the fourth-order crossover: stream ports, sequencer and datapath glue.
`timescale 1ns / 1ps
// Usage
//   Input words carry one sample per voice on s_tdata and a per-voice clear
//   mask on s_tuser. Each accepted word yields exactly one output word on
//   m_tdata with the low band of every voice followed by the high band.
//   Every band runs two cascaded biquads; all 5 products of a biquad go
//   through one shared multiplier, and the history of each biquad lives in
//   one word of a single-port synchronous memory (read, compute, write back).
//   Coefficients must be written through cfg_we / cfg_index / cfg_wdata
//   only while idle, not enforced by the block; they apply to the next input word.
// Processing order
//   Each biquad runs a memory read, the product taps and a drain step,
//   then a round/write-back step. A word holds 4*VOICES biquads, and the
//   next input word is taken only once the finished word has moved into
//   the output register.
// Reset and stalls
//   aresetn (synchronous, active low) zeroes coefficients and marks all
//   history empty, so the filters start from silence. If the receiver holds
//   m_tready low, the finished word waits in the output register and the
//   block still takes and filters the next input word; it then holds that
//   result until the output register frees up.
module lr4_crossover_split #(
    parameter int VOICES         = 4,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_BITS      = 32,
    parameter int COEF_FRAC_BITS = 29
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // s_tdata, from bit 0 up: sample_v0 .. sample_v(VOICES-1), zero padding
    input  logic [((VOICES*SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,
    // s_tuser, from bit 0 up: clear_voices
    input  logic [VOICES-1:0]                            s_tuser,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // m_tdata, from bit 0 up: low_v0 .. low_v(VOICES-1), high_v0 .., zero padding
    output logic [((2*VOICES*SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    input  logic                                         cfg_we,
    input  logic [lr4x_pkg::REG_IDX_W-1:0]               cfg_index,
    input  logic [COEF_BITS-1:0]                         cfg_wdata
);

    localparam int VOICE_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int HIST_AW = $clog2(VOICES*4);
    localparam int SLOTS   = 2 * VOICES;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int WORD_W  = 4 * SAMPLE_BITS;

    lr4x_pkg::seq_state_t state_reg, state_next;

    logic [VOICE_W-1:0]              voice_reg, voice_next;
    logic                            band_reg, band_next;
    logic                            stage_reg, stage_next;
    logic [lr4x_pkg::TAP_W-1:0]      tap_reg, tap_next;

    logic signed [SAMPLE_BITS-1:0]   smp_reg [VOICES];
    logic [VOICES-1:0]               clr_mask;
    logic signed [SAMPLE_BITS-1:0]   stage_out_reg;
    logic signed [SAMPLE_BITS-1:0]   res_reg [SLOTS];
    logic signed [SAMPLE_BITS-1:0]   out_reg [SLOTS];
    logic                            m_valid_reg, m_valid_next;

    logic                            s_accept;
    logic                            out_load;
    lr4x_pkg::hist_ctrl_t            hist_ctrl;
    lr4x_pkg::mac_ctrl_t             mac_ctrl;
    logic [HIST_AW-1:0]              hist_addr;
    logic [WORD_W-1:0]               rd_word;
    logic [WORD_W-1:0]               wr_word;
    logic [lr4x_pkg::REG_IDX_W-1:0]  coef_idx;
    logic signed [COEF_BITS-1:0]     coef;
    logic signed [SAMPLE_BITS-1:0]   x_cur;
    logic signed [SAMPLE_BITS-1:0]   x1, x2, y1, y2;
    logic signed [SAMPLE_BITS-1:0]   mac_sample;
    logic signed [SAMPLE_BITS-1:0]   q;
    logic [SLOT_W-1:0]               slot;

    assign s_tready = (state_reg == lr4x_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign clr_mask = s_tuser;

    // History word layout from bit 0 up: x1, x2, y1, y2
    assign x1 = rd_word[0*SAMPLE_BITS +: SAMPLE_BITS];
    assign x2 = rd_word[1*SAMPLE_BITS +: SAMPLE_BITS];
    assign y1 = rd_word[2*SAMPLE_BITS +: SAMPLE_BITS];
    assign y2 = rd_word[3*SAMPLE_BITS +: SAMPLE_BITS];

    // First stage eats the voice sample, second stage the first stage output
    assign x_cur = stage_reg ? stage_out_reg : smp_reg[voice_reg];

    // Shift the taps: x2 <- x1, x1 <- x, y2 <- y1, y1 <- q
    assign wr_word = {y1, q, x1, x_cur};

    assign hist_addr = HIST_AW'({voice_reg, band_reg, stage_reg});
    assign slot = band_reg ? (SLOT_W'(VOICES) + SLOT_W'(voice_reg)) : SLOT_W'(voice_reg);

    // Operand selection per tap
    always_comb begin
        case (tap_reg)
            lr4x_pkg::TAP_X0: begin
                mac_sample = x_cur;
                coef_idx   = band_reg ? lr4x_pkg::REG_HIGH_FF0 : lr4x_pkg::REG_LOW_FF0;
            end
            lr4x_pkg::TAP_X1: begin
                mac_sample = x1;
                coef_idx   = band_reg ? lr4x_pkg::REG_HIGH_FF1 : lr4x_pkg::REG_LOW_FF1;
            end
            lr4x_pkg::TAP_X2: begin
                mac_sample = x2;
                coef_idx   = band_reg ? lr4x_pkg::REG_HIGH_FF2 : lr4x_pkg::REG_LOW_FF2;
            end
            lr4x_pkg::TAP_Y1: begin
                mac_sample = y1;
                coef_idx   = lr4x_pkg::REG_FB1;
            end
            default: begin
                mac_sample = y2;
                coef_idx   = lr4x_pkg::REG_FB2;
            end
        endcase
    end

    // Sequencer: voice, band, stage, then the product taps of one biquad
    always_comb begin
        state_next   = state_reg;
        voice_next   = voice_reg;
        band_next    = band_reg;
        stage_next   = stage_reg;
        tap_next     = tap_reg;
        hist_ctrl    = '0;
        mac_ctrl     = '0;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;

        unique case (state_reg)
            lr4x_pkg::ST_IDLE: begin
                if (s_accept) begin
                    hist_ctrl.clr_en = 1'b1;
                    voice_next       = '0;
                    band_next        = 1'b0;
                    stage_next       = 1'b0;
                    state_next       = lr4x_pkg::ST_READ;
                end
            end
            lr4x_pkg::ST_READ: begin
                hist_ctrl.rd_en = 1'b1;
                tap_next        = lr4x_pkg::TAP_X0;
                state_next      = lr4x_pkg::ST_MAC;
            end
            lr4x_pkg::ST_MAC: begin
                mac_ctrl.init   = (tap_reg == lr4x_pkg::TAP_X0);
                mac_ctrl.mul_en = (tap_reg != lr4x_pkg::TAP_DRAIN);
                mac_ctrl.acc_en = (tap_reg != lr4x_pkg::TAP_X0);
                if (tap_reg == lr4x_pkg::TAP_DRAIN) begin
                    state_next = lr4x_pkg::ST_ROUND;
                end else begin
                    tap_next = tap_reg + lr4x_pkg::TAP_W'(1);
                end
            end
            lr4x_pkg::ST_ROUND: begin
                hist_ctrl.wr_en = 1'b1;
                state_next      = lr4x_pkg::ST_READ;
                if (!stage_reg) begin
                    stage_next = 1'b1;
                end else begin
                    stage_next = 1'b0;
                    if (!band_reg) begin
                        band_next = 1'b1;
                    end else begin
                        band_next = 1'b0;
                        if (voice_reg == VOICE_W'(VOICES - 1)) begin
                            state_next = lr4x_pkg::ST_FINISH;
                        end else begin
                            voice_next = voice_reg + VOICE_W'(1);
                        end
                    end
                end
            end
            lr4x_pkg::ST_FINISH: begin
                // Hand the word over once the output register is free
                if (!m_valid_reg || m_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = lr4x_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lr4x_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lr4x_pkg::ST_IDLE;
            voice_reg   <= '0;
            band_reg    <= 1'b0;
            stage_reg   <= 1'b0;
            tap_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            voice_reg   <= voice_next;
            band_reg    <= band_next;
            stage_reg   <= stage_next;
            tap_reg     <= tap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int v = 0; v < VOICES; v++) begin
                smp_reg[v] <= $signed(s_tdata[v*SAMPLE_BITS +: SAMPLE_BITS]);
            end
        end
        if (state_reg == lr4x_pkg::ST_ROUND) begin
            stage_out_reg <= q;
            if (stage_reg) begin
                res_reg[slot] <= q;
            end
        end
        if (out_load) begin
            for (int i = 0; i < SLOTS; i++) begin
                out_reg[i] <= res_reg[i];
            end
        end
    end

    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < SLOTS; i++) begin
            m_tdata[i*SAMPLE_BITS +: SAMPLE_BITS] = out_reg[i];
        end
    end

    assign m_tvalid = m_valid_reg;

    lr4x_coef_regs #(
        .COEF_BITS (COEF_BITS)
    ) u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rd_index  (coef_idx),
        .rd_coef   (coef)
    );

    lr4x_hist_mem #(
        .VOICES      (VOICES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_hist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (hist_ctrl),
        .addr     (hist_addr),
        .clr_mask (clr_mask),
        .wr_word  (wr_word),
        .rd_word  (rd_word)
    );

    lr4x_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_BITS      (COEF_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .sample (mac_sample),
        .coef   (coef),
        .result (q)
    );

    // An accepted word always starts with a history read
    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == lr4x_pkg::ST_READ)
        else $error("accepted word did not start a history read");

    // A history read is always followed by the first product tap
    a_read_to_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lr4x_pkg::ST_READ |=>
            state_reg == lr4x_pkg::ST_MAC && tap_reg == lr4x_pkg::TAP_X0)
        else $error("history read not followed by first tap");

    // The drain tap always hands over to round and write back
    a_drain_to_round: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lr4x_pkg::ST_MAC && tap_reg == lr4x_pkg::TAP_DRAIN |=>
            state_reg == lr4x_pkg::ST_ROUND)
        else $error("accumulation did not end in write back");

    // A finished word offered to a free output register shows up as valid
    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lr4x_pkg::ST_FINISH && (!m_valid_reg || m_tready) |=>
            m_valid_reg && state_reg == lr4x_pkg::ST_IDLE)
        else $error("finished word not presented");

endmodule
